[rtl/tprs_pkg.sv]
// shared widths, reset values and status codes of the prescaler and reload solver
package tprs_pkg;

  localparam int unsigned FreqW     = 32;
  localparam int unsigned ClockW    = 29;
  localparam int unsigned FieldW    = 16;
  localparam int unsigned DivisorW  = 48;
  localparam int unsigned DividendW = 33;
  localparam int unsigned ReloadW   = 30;
  localparam int unsigned CntW      = 6;
  localparam int unsigned AddrW     = 3;
  localparam int unsigned DataW     = 32;

  localparam logic [ClockW-1:0] ClockReset = 29'd275000000;
  localparam logic [CntW-1:0]   LastStep   = 6'd32;
  localparam logic [DividendW-1:0] RoundThreshold = 33'd5;
  localparam logic [FieldW-1:0] FieldMax   = 16'hFFFF;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ZERO_FREQ = 2'd1,
    ST_TOO_HIGH  = 2'd2
  } status_e;

endpackage

[rtl/tprs_if.sv]
// valid/ready channel interfaces for frequency requests and solver results
interface tprs_in_if;
  logic                         valid;
  logic                         ready;
  logic [tprs_pkg::FreqW-1:0]   target_hz;

  modport source (output valid, output target_hz, input ready);
  modport sink   (input valid, input target_hz, output ready);
endinterface

interface tprs_out_if;
  logic                          valid;
  logic                          ready;
  logic [tprs_pkg::FieldW-1:0]   prescale_value;
  logic [tprs_pkg::FieldW-1:0]   reload_value;
  tprs_pkg::status_e             status;

  modport source (output valid, output prescale_value, output reload_value, output status,
                  input ready);
  modport sink   (input valid, input prescale_value, input reload_value, input status,
                  output ready);
endinterface

[rtl/timer_prescaler_reload_solver.sv]
// prescaler and auto-reload search with bit-serial restoring division
//
//   channel   dir   word / access
//   in_i      sink  target_hz, 32 bits
//   out_o     src   prescale_value 16, reload_value 16, status 2
//   apb       slv   clock_hz at byte address 0, 29 bits, read back on prdata
//
// each prescaler tried takes 33 shift/subtract steps of the two
// dividers (clock and ten times clock, sharing one divisor) and one check
// a zero frequency goes straight to the result, without any division
// reset returns the clock register to 275000000 and drops any pending word
// a new word is taken while the previous result still waits on out_o
module timer_prescaler_reload_solver #(
  parameter longint unsigned RELOAD_LIMIT = 64'd65536
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  tprs_in_if.sink                       in_i,
  tprs_out_if.source                    out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tprs_pkg::AddrW-1:0]    paddr,
  input  logic [tprs_pkg::DataW-1:0]    pwdata,
  output logic [tprs_pkg::DataW-1:0]    prdata,
  output logic                          pready
);

  localparam logic [32:0] LimitW = 33'(RELOAD_LIMIT);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_CHECK, S_DONE} state_e;

  state_e                           state_q, state_d;
  logic [tprs_pkg::ClockW-1:0]      clock_q;
  logic [tprs_pkg::FreqW-1:0]       freq_q, freq_d;
  logic [tprs_pkg::DivisorW-1:0]    div_q, div_d;
  logic [tprs_pkg::FieldW-1:0]      p_q, p_d;
  logic [tprs_pkg::CntW-1:0]        cnt_q, cnt_d;
  logic [tprs_pkg::DividendW-1:0]   shc_q, shc_d, sht_q, sht_d;
  logic [tprs_pkg::DividendW-1:0]   rc_q, rc_d, rt_q, rt_d;
  logic [tprs_pkg::ClockW-1:0]      quo_q, quo_d;
  logic [tprs_pkg::FieldW-1:0]      res_pre_q, res_pre_d, res_rel_q, res_rel_d;
  tprs_pkg::status_e                res_st_q, res_st_d;
  logic                             ov_q, ov_d;
  logic [tprs_pkg::FieldW-1:0]      o_pre_q, o_pre_d, o_rel_q, o_rel_d;
  tprs_pkg::status_e                o_st_q, o_st_d;

  logic [tprs_pkg::DividendW-1:0]   tenfold;
  logic [tprs_pkg::DividendW:0]     rc_sh, rt_sh, rc_sub, rt_sub;
  logic                             div_fits, c_ge, t_ge;
  logic [tprs_pkg::ReloadW-1:0]     reload, zb;
  logic                             reload_ok, out_free, cfg_wr;

  // configuration register
  assign cfg_wr = psel && penable && pwrite && !paddr[2];
  assign pready = 1'b1;
  assign prdata = paddr[2] ? '0 : {3'b000, clock_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_q <= tprs_pkg::ClockReset;
    end else if (cfg_wr) begin
      clock_q <= pwdata[tprs_pkg::ClockW-1:0];
    end
  end

  // clock * 10 as (clock << 3) + (clock << 1)
  assign tenfold = 33'({clock_q, 3'b000}) + 33'({clock_q, 1'b0});

  // one restoring step for each dividend; partial remainders stay below 2^33
  assign rc_sh    = {rc_q, shc_q[tprs_pkg::DividendW-1]};
  assign rt_sh    = {rt_q, sht_q[tprs_pkg::DividendW-1]};
  assign div_fits = (div_q[tprs_pkg::DivisorW-1:34] == '0);
  assign c_ge     = div_fits && (rc_sh >= div_q[33:0]);
  assign t_ge     = div_fits && (rt_sh >= div_q[33:0]);
  assign rc_sub   = rc_sh - div_q[33:0];
  assign rt_sub   = rt_sh - div_q[33:0];

  assign reload    = {1'b0, quo_q} + 30'(rt_q >= tprs_pkg::RoundThreshold);
  assign zb        = reload - 30'd1;
  assign reload_ok = ({3'b000, reload} < LimitW);
  assign out_free  = !ov_q || out_o.ready;

  assign in_i.ready           = (state_q == S_IDLE);
  assign out_o.valid          = ov_q;
  assign out_o.prescale_value = o_pre_q;
  assign out_o.reload_value   = o_rel_q;
  assign out_o.status         = o_st_q;

  always_comb begin
    state_d   = state_q;
    freq_d    = freq_q;
    div_d     = div_q;
    p_d       = p_q;
    cnt_d     = cnt_q;
    shc_d     = shc_q;
    sht_d     = sht_q;
    rc_d      = rc_q;
    rt_d      = rt_q;
    quo_d     = quo_q;
    res_pre_d = res_pre_q;
    res_rel_d = res_rel_q;
    res_st_d  = res_st_q;
    ov_d      = ov_q;
    o_pre_d   = o_pre_q;
    o_rel_d   = o_rel_q;
    o_st_d    = o_st_q;

    if (ov_q && out_o.ready) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          freq_d = in_i.target_hz;
          if (in_i.target_hz == '0) begin
            res_pre_d = '0;
            res_rel_d = '0;
            res_st_d  = tprs_pkg::ST_ZERO_FREQ;
            state_d   = S_DONE;
          end else begin
            div_d   = {16'h0000, in_i.target_hz};
            p_d     = '0;
            shc_d   = {4'h0, clock_q};
            sht_d   = tenfold;
            rc_d    = '0;
            rt_d    = '0;
            quo_d   = '0;
            cnt_d   = '0;
            state_d = S_DIV;
          end
        end
      end
      S_DIV: begin
        shc_d = {shc_q[tprs_pkg::DividendW-2:0], 1'b0};
        sht_d = {sht_q[tprs_pkg::DividendW-2:0], 1'b0};
        rc_d  = c_ge ? rc_sub[tprs_pkg::DividendW-1:0] : rc_sh[tprs_pkg::DividendW-1:0];
        rt_d  = t_ge ? rt_sub[tprs_pkg::DividendW-1:0] : rt_sh[tprs_pkg::DividendW-1:0];
        quo_d = {quo_q[tprs_pkg::ClockW-2:0], c_ge};
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == tprs_pkg::LastStep) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (reload_ok) begin
          if (reload == '0) begin
            res_pre_d = '0;
            res_rel_d = '0;
            res_st_d  = tprs_pkg::ST_TOO_HIGH;
          end else begin
            res_pre_d = p_q;
            res_rel_d = (zb[tprs_pkg::ReloadW-1:16] != '0) ? tprs_pkg::FieldMax
                                                           : zb[15:0];
            res_st_d  = tprs_pkg::ST_OK;
          end
          state_d = S_DONE;
        end else if (p_q == tprs_pkg::FieldMax) begin
          // search ran out: saturate
          res_pre_d = tprs_pkg::FieldMax;
          res_rel_d = tprs_pkg::FieldMax;
          res_st_d  = tprs_pkg::ST_OK;
          state_d   = S_DONE;
        end else begin
          p_d     = p_q + 16'd1;
          div_d   = div_q + {16'h0000, freq_q};
          shc_d   = {4'h0, clock_q};
          sht_d   = tenfold;
          rc_d    = '0;
          rt_d    = '0;
          quo_d   = '0;
          cnt_d   = '0;
          state_d = S_DIV;
        end
      end
      S_DONE: begin
        if (out_free) begin
          ov_d    = 1'b1;
          o_pre_d = res_pre_q;
          o_rel_d = res_rel_q;
          o_st_d  = res_st_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      freq_q    <= '0;
      div_q     <= '0;
      p_q       <= '0;
      cnt_q     <= '0;
      shc_q     <= '0;
      sht_q     <= '0;
      rc_q      <= '0;
      rt_q      <= '0;
      quo_q     <= '0;
      res_pre_q <= '0;
      res_rel_q <= '0;
      res_st_q  <= tprs_pkg::ST_OK;
      ov_q      <= 1'b0;
      o_pre_q   <= '0;
      o_rel_q   <= '0;
      o_st_q    <= tprs_pkg::ST_OK;
    end else begin
      state_q   <= state_d;
      freq_q    <= freq_d;
      div_q     <= div_d;
      p_q       <= p_d;
      cnt_q     <= cnt_d;
      shc_q     <= shc_d;
      sht_q     <= sht_d;
      rc_q      <= rc_d;
      rt_q      <= rt_d;
      quo_q     <= quo_d;
      res_pre_q <= res_pre_d;
      res_rel_q <= res_rel_d;
      res_st_q  <= res_st_d;
      ov_q      <= ov_d;
      o_pre_q   <= o_pre_d;
      o_rel_q   <= o_rel_d;
      o_st_q    <= o_st_d;
    end
  end

  // step counter never runs past the last division step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (cnt_q <= tprs_pkg::LastStep))
    else $error("division step counter overran");

  // a divisor of zero would make every step subtract
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (div_q != '0))
    else $error("zero divisor during division");

  // a zero frequency word is answered without any division
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && (in_i.target_hz == '0))
      |=> (state_q == S_DONE && res_st_q == tprs_pkg::ST_ZERO_FREQ))
    else $error("zero frequency not flagged");

  // error results carry zero prescaler and reload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && (o_st_q != tprs_pkg::ST_OK)) |-> (o_pre_q == '0 && o_rel_q == '0))
    else $error("error result with nonzero fields");

endmodule
